[hw/rtl/trbw_pkg.sv]
// Shared types and constants for the tricolor bit-plane rectangle writer.
`timescale 1ns / 1ps

package trbw_pkg;

	localparam int DIM_W    = 11;
	localparam int COLOR_W  = 16;
	localparam int IDX_W    = 13;
	localparam int DATA_W   = 8;
	localparam int STRIDE_W = DIM_W - 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [DATA_W-1:0] BIT_MSB = 8'h80;

	localparam logic [DIM_W-1:0]   VIEW_WIDTH_RST   = 11'd264;
	localparam logic [DIM_W-1:0]   VIEW_HEIGHT_RST  = 11'd176;
	localparam logic [DIM_W-1:0]   PANEL_WIDTH_RST  = 11'd176;
	localparam logic [DIM_W-1:0]   PANEL_HEIGHT_RST = 11'd264;
	localparam logic [COLOR_W-1:0] RED_CODE_RST     = 16'hF800;
	localparam logic [COLOR_W-1:0] BLACK_CODE_RST   = 16'h0000;

	typedef enum logic [1:0] {
		OP_FILL  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_PIXEL = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_WIDTH   = 3'd0,
		REG_VIEW_HEIGHT  = 3'd1,
		REG_PANEL_WIDTH  = 3'd2,
		REG_PANEL_HEIGHT = 3'd3,
		REG_PORTRAIT     = 3'd4,
		REG_RED_CODE     = 3'd5,
		REG_BLACK_CODE   = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX_ADDR,
		ST_PIX_READ,
		ST_PIX_WRITE,
		ST_RD_LIM,
		ST_RD_CHECK,
		ST_RD_DATA,
		ST_FINISH
	} state_t;

	// Geometry seen by the address unit.
	typedef struct packed {
		logic [DIM_W-1:0] view_height;
		logic [DIM_W-1:0] panel_width;
		logic [DIM_W-1:0] panel_height;
		logic             portrait;
	} geom_cfg_t;

endpackage

[hw/rtl/trbw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module trbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/trbw_addr_unit.sv]
// Shared address unit: pixel byte address and bit mask, or readout byte limit.
`timescale 1ns / 1ps

module trbw_addr_unit import trbw_pkg::*; #(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  kind_limit,
	input  logic [COORD_BITS-1:0] x,
	input  logic [COORD_BITS-1:0] y,
	input  geom_cfg_t             geom,
	output logic [((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W)+STRIDE_W:0] addr_q,
	output logic [DATA_W-1:0]     mask_q,
	output logic                  skip_q
);

	localparam int MW = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
	localparam int RW = MW + STRIDE_W + 1;

	logic [DIM_W:0]          pw_round;
	logic [STRIDE_W-1:0]     stride;
	logic [DIM_W-1:0]        h_eff;
	logic [MW:0]             diff;
	logic [MW-1:0]           col;
	logic [MW-1:0]           row;
	logic                    neg;
	logic [MW-1:0]           mul_a;
	logic [MW-4:0]           col_byte;
	logic [MW+STRIDE_W-1:0]  prod;
	logic [RW-1:0]           sum;

	always_comb begin
		pw_round = {1'b0, geom.panel_width} + (DIM_W+1)'(7);
		stride   = pw_round[DIM_W:3];
		h_eff    = (geom.view_height == '0) ? DIM_W'(1) : geom.view_height;
		// portrait column = height-1-y; top bit flags y beyond the view
		diff     = (MW+1)'(h_eff) - (MW+1)'(1) - (MW+1)'(y);
		if (geom.portrait) begin
			col = diff[MW-1:0];
			row = MW'(x);
			neg = diff[MW];
		end else begin
			col = MW'(x);
			row = MW'(y);
			neg = 1'b0;
		end
		mul_a    = kind_limit ? MW'(geom.panel_height) : row;
		col_byte = kind_limit ? '0 : col[MW-1:3];
		prod     = mul_a * stride;
		sum      = RW'(prod) + RW'(col_byte);
	end

	always_ff @(posedge clk) begin
		addr_q <= sum;
		mask_q <= BIT_MSB >> col[2:0];
		skip_q <= neg & ~kind_limit;
	end

endmodule

[hw/rtl/tricolor_bitplane_rect_writer.sv]
// Top level: two bit planes, image window and the operation sequencer.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in_valid/in_stall    | operation, x/y bounds, color, byte_index,
//           |                      | plane_select
//   out     | out_valid/out_stall  | read_data, image_done
//
// Open, and a pixel with no window open, go from idle to finish; an image pixel
// runs address, read and write, a byte read runs limit, check and data, and a
// fill repeats address, read and write per covered pixel (an empty fill goes
// to finish); each pixel is a read-modify-write of both planes through the
// shared address unit and the single read/write port pair. A clearing pass
// after reset zeroes both planes, with in_stall high; configuration writes are
// taken throughout. A result waits in the output register while the next
// transfer is accepted; only the end of an operation waits on a stalled output.
`timescale 1ns / 1ps

module tricolor_bitplane_rect_writer import trbw_pkg::*; #(
	parameter int PLANE_BYTES = 8192,
	parameter int COORD_BITS  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// operations
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            operation,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_W-1:0]    color,
	input  logic [IDX_W-1:0]      byte_index,
	input  logic                  plane_select,
	// results
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_W-1:0]     read_data,
	output logic                  image_done
);

	localparam int CW = COORD_BITS;
	localparam int MW = (CW > DIM_W) ? CW : DIM_W;
	localparam int RW = MW + STRIDE_W + 1;
	localparam int AW = $clog2(PLANE_BYTES);

	function automatic logic [CW-1:0] clamp_c(input logic [CW-1:0] v,
		input logic [DIM_W-1:0] dim);
		logic [MW-1:0] ve;
		logic [MW-1:0] de;
		ve = MW'(v);
		de = MW'(dim);
		clamp_c = (ve >= de) ? CW'(de - MW'(1)) : v;
	endfunction

	// config registers
	logic [DIM_W-1:0]   view_width_q, view_height_q, panel_width_q, panel_height_q;
	logic               portrait_q;
	logic [COLOR_W-1:0] red_code_q, black_code_q;

	// sequencer and operation registers
	state_t             state_q, state_d;
	op_t                op_q;
	logic [COLOR_W-1:0] color_q;
	logic [IDX_W-1:0]   idx_q;
	logic               plane_q;
	logic [CW-1:0]      sx_q, ex_q, ey_q;
	logic [CW-1:0]      px_q, py_q;
	logic [AW-1:0]      clr_q;
	logic               rd_ok_q;
	logic [DATA_W-1:0]  res_data_q;
	logic               res_done_q;

	// image window
	logic [CW-1:0]      win_x0_q, win_x1_q, win_y1_q;
	logic [CW-1:0]      win_cx_q, win_cy_q;
	logic               win_active_q;

	// output register
	logic               out_valid_q;
	logic [DATA_W-1:0]  read_data_q;
	logic               image_done_q;

	// address unit
	geom_cfg_t          geom;
	logic [RW-1:0]      u_addr;
	logic [DATA_W-1:0]  u_mask;
	logic               u_skip;

	// plane RAM ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [DATA_W-1:0]  blk_wdata, red_wdata, blk_rdata, red_rdata;
	logic [IDX_W+AW-1:0] idx_wide;

	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [CW-1:0]      csx, cex, csy, cey;
	logic               fill_empty, fill_last, in_acc, out_load, pix_ok;
	logic               is_red, is_black;

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign image_done = image_done_q;

	assign geom = '{view_height: view_height_q, panel_width: panel_width_q,
		panel_height: panel_height_q, portrait: portrait_q};

	trbw_addr_unit #(.COORD_BITS(CW)) u_addr_unit (
		.clk       (clk),
		.kind_limit(op_q == OP_READ),
		.x         (px_q),
		.y         (py_q),
		.geom      (geom),
		.addr_q    (u_addr),
		.mask_q    (u_mask),
		.skip_q    (u_skip)
	);

	trbw_ram #(.WIDTH(DATA_W), .DEPTH(PLANE_BYTES)) u_black_plane (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(blk_wdata),
		.raddr(ram_raddr),
		.rdata(blk_rdata)
	);

	trbw_ram #(.WIDTH(DATA_W), .DEPTH(PLANE_BYTES)) u_red_plane (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(red_wdata),
		.raddr(ram_raddr),
		.rdata(red_rdata)
	);

	// clamp incoming rectangle to the view; zero dimension acts as one
	assign w_eff      = (view_width_q == '0) ? DIM_W'(1) : view_width_q;
	assign h_eff      = (view_height_q == '0) ? DIM_W'(1) : view_height_q;
	assign csx        = clamp_c(x_start, w_eff);
	assign cex        = clamp_c(x_end, w_eff);
	assign csy        = clamp_c(y_start, h_eff);
	assign cey        = clamp_c(y_end, h_eff);
	assign fill_empty = (csx > cex) || (csy > cey);
	assign fill_last  = (px_q >= ex_q) && (py_q >= ey_q);

	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign pix_ok   = !u_skip && (32'(u_addr) < 32'(PLANE_BYTES));
	assign is_red   = (color_q == red_code_q);
	assign is_black = (color_q == black_code_q);
	assign idx_wide = (IDX_W+AW)'(idx_q);

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q   <= VIEW_WIDTH_RST;
			view_height_q  <= VIEW_HEIGHT_RST;
			panel_width_q  <= PANEL_WIDTH_RST;
			panel_height_q <= PANEL_HEIGHT_RST;
			portrait_q     <= 1'b0;
			red_code_q     <= RED_CODE_RST;
			black_code_q   <= BLACK_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VIEW_WIDTH:   view_width_q   <= cfg_data[DIM_W-1:0];
				REG_VIEW_HEIGHT:  view_height_q  <= cfg_data[DIM_W-1:0];
				REG_PANEL_WIDTH:  panel_width_q  <= cfg_data[DIM_W-1:0];
				REG_PANEL_HEIGHT: panel_height_q <= cfg_data[DIM_W-1:0];
				REG_PORTRAIT:     portrait_q     <= cfg_data[0];
				REG_RED_CODE:     red_code_q     <= cfg_data;
				REG_BLACK_CODE:   black_code_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, stall and plane port control
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = u_addr[AW-1:0];
		ram_raddr = u_addr[AW-1:0];
		blk_wdata = '0;
		red_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == AW'(PLANE_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (op_t'(operation))
						OP_FILL:  state_d = fill_empty ? ST_FINISH : ST_PIX_ADDR;
						OP_OPEN:  state_d = ST_FINISH;
						OP_PIXEL: state_d = win_active_q ? ST_PIX_ADDR : ST_FINISH;
						default:  state_d = ST_RD_LIM;
					endcase
				end
			end
			ST_PIX_ADDR: state_d = ST_PIX_READ;
			ST_PIX_READ: state_d = ST_PIX_WRITE;
			ST_PIX_WRITE: begin
				// red wins over black when both codes match
				ram_we    = pix_ok;
				blk_wdata = (!is_red && is_black) ? (blk_rdata | u_mask)
					: (blk_rdata & ~u_mask);
				red_wdata = is_red ? (red_rdata | u_mask) : (red_rdata & ~u_mask);
				state_d   = (op_q == OP_FILL && !fill_last) ? ST_PIX_ADDR : ST_FINISH;
			end
			ST_RD_LIM: state_d = ST_RD_CHECK;
			ST_RD_CHECK: begin
				ram_raddr = idx_wide[AW-1:0];
				state_d   = ST_RD_DATA;
			end
			ST_RD_DATA: state_d = ST_FINISH;
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control datapath: clear counter, image window, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			win_x0_q     <= '0;
			win_x1_q     <= '0;
			win_y1_q     <= '0;
			win_cx_q     <= '0;
			win_cy_q     <= '0;
			win_active_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (in_acc && op_t'(operation) == OP_OPEN) begin
				win_x0_q     <= csx;
				win_x1_q     <= cex;
				win_y1_q     <= cey;
				win_cx_q     <= csx;
				win_cy_q     <= csy;
				win_active_q <= !fill_empty;
			end else if (in_acc && op_t'(operation) == OP_PIXEL && win_active_q) begin
				// row-major walk of the window
				if (win_cx_q >= win_x1_q) begin
					if (win_cy_q >= win_y1_q) begin
						win_active_q <= 1'b0;
					end else begin
						win_cx_q <= win_x0_q;
						win_cy_q <= win_cy_q + CW'(1);
					end
				end else begin
					win_cx_q <= win_cx_q + CW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q       <= op_t'(operation);
			color_q    <= color;
			idx_q      <= byte_index;
			plane_q    <= plane_select;
			res_data_q <= '0;
			res_done_q <= 1'b0;
			case (op_t'(operation))
				OP_FILL: begin
					sx_q <= csx;
					ex_q <= cex;
					ey_q <= cey;
					px_q <= csx;
					py_q <= csy;
				end
				OP_PIXEL: begin
					px_q       <= win_cx_q;
					py_q       <= win_cy_q;
					res_done_q <= win_active_q && (win_cx_q >= win_x1_q)
						&& (win_cy_q >= win_y1_q);
				end
				default: ;
			endcase
		end
		if (state_q == ST_PIX_WRITE && op_q == OP_FILL && !fill_last) begin
			if (px_q >= ex_q) begin
				px_q <= sx_q;
				py_q <= py_q + CW'(1);
			end else begin
				px_q <= px_q + CW'(1);
			end
		end
		if (state_q == ST_RD_CHECK) begin
			rd_ok_q <= (RW'(idx_q) < u_addr) && (32'(idx_q) < 32'(PLANE_BYTES));
		end
		if (state_q == ST_RD_DATA) begin
			res_data_q <= !rd_ok_q ? '0 : (plane_q ? red_rdata : blk_rdata);
		end
		if (out_load) begin
			read_data_q  <= res_data_q;
			image_done_q <= res_done_q;
		end
	end

endmodule
